FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// An implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// An implication whose consequent is checked in the cycle after its antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: hw/rtl/brs_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear scaler package
// Shared types and constants of the bilinear RGBA scaler.
// ----------------------------------------------------------------------------
package brs_pkg;
	localparam int MAX_WIDTH = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int FRACTION_BITS = 8;
	localparam int STEP_FRAC = 16;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int FW = FRACTION_BITS;
	localparam int SUM_SHIFT = 2 * FW;
	localparam int WW = 2 * FW + 1;
	localparam int SW = WW + 8 + 2;
	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_HSTEP = 2'd2;
	localparam logic [1:0] REG_VSTEP = 2'd3;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	typedef logic [31:0] pixel_t;

	typedef struct packed {
		logic [XW-1:0] x0;
		logic [XW-1:0] x1;
		logic [YW-1:0] y0;
		logic [YW-1:0] y1;
		logic [FW-1:0] fx;
		logic [FW-1:0] fy;
	} coord_t;
endpackage

FILE: hw/rtl/brs_addr.sv
// ----------------------------------------------------------------------------
// Bilinear scaler address stage
// Multiplies the destination position by the steps and clamps the neighbours.
// ----------------------------------------------------------------------------
module brs_addr import brs_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [7:0]    column,
	input  logic [7:0]    row,
	input  logic [23:0]   hstep,
	input  logic [23:0]   vstep,
	input  logic [XW:0]   wid,
	input  logic [YW:0]   hgt,
	output coord_t        coord
);
	logic [31:0] xs_s1, ys_s1;
	logic [XW:0] wlast, xi_c, x1_c;
	logic [YW:0] hlast, yi_c, y1_c;
	logic [15:0] xint, yint;

	always_ff @(posedge clk) begin
		if (en) begin
			xs_s1 <= 32'(column) * 32'(hstep);
			ys_s1 <= 32'(row) * 32'(vstep);
		end
	end

	always_comb begin
		wlast = wid - 1'b1;
		hlast = hgt - 1'b1;
		xint = xs_s1[31:16];
		yint = ys_s1[31:16];
		xi_c = (xint > 16'(wlast)) ? wlast : (XW+1)'(xint);
		yi_c = (yint > 16'(hlast)) ? hlast : (YW+1)'(yint);
		x1_c = (xi_c + 1'b1 > wlast) ? wlast : xi_c + 1'b1;
		y1_c = (yi_c + 1'b1 > hlast) ? hlast : yi_c + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coord.x0 <= xi_c[XW-1:0];
			coord.x1 <= x1_c[XW-1:0];
			coord.y0 <= yi_c[YW-1:0];
			coord.y1 <= y1_c[YW-1:0];
			coord.fx <= xs_s1[STEP_FRAC-1 -: FW];
			coord.fy <= ys_s1[STEP_FRAC-1 -: FW];
		end
	end
endmodule

FILE: hw/rtl/brs_store.sv
// ----------------------------------------------------------------------------
// Bilinear scaler frame store
// Four copies of the source image, one per neighbour, each with one read port.
// ----------------------------------------------------------------------------
module brs_store import brs_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic                wr_en,
	input  logic [XW+YW-1:0]    wr_addr,
	input  pixel_t              wr_data,
	input  coord_t              coord,
	output pixel_t              p00,
	output pixel_t              p10,
	output pixel_t              p01,
	output pixel_t              p11
);
	pixel_t mem00 [MAX_WIDTH*MAX_HEIGHT];
	pixel_t mem10 [MAX_WIDTH*MAX_HEIGHT];
	pixel_t mem01 [MAX_WIDTH*MAX_HEIGHT];
	pixel_t mem11 [MAX_WIDTH*MAX_HEIGHT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem00[wr_addr] <= wr_data;
			mem10[wr_addr] <= wr_data;
			mem01[wr_addr] <= wr_data;
			mem11[wr_addr] <= wr_data;
		end
		if (en) begin
			p00 <= mem00[{coord.y0, coord.x0}];
			p10 <= mem10[{coord.y0, coord.x1}];
			p01 <= mem01[{coord.y1, coord.x0}];
			p11 <= mem11[{coord.y1, coord.x1}];
		end
	end
endmodule

FILE: hw/rtl/brs_blend.sv
// ----------------------------------------------------------------------------
// Bilinear scaler blend stages
// Forms the four weights, multiplies each channel and rounds the sums.
// ----------------------------------------------------------------------------
module brs_blend import brs_pkg::*; (
	input  logic          clk,
	input  logic          en_w,
	input  logic          en_m,
	input  logic          en_o,
	input  logic [FW-1:0] fx,
	input  logic [FW-1:0] fy,
	input  pixel_t        p00,
	input  pixel_t        p10,
	input  pixel_t        p01,
	input  pixel_t        p11,
	output pixel_t        result
);
	localparam logic [FW:0] ONE = (FW+1)'(1) << FW;
	logic [WW-1:0] w00_s4, w10_s4, w01_s4, w11_s4;
	pixel_t q00_s4, q10_s4, q01_s4, q11_s4;
	logic [SW-1:0] sum_s5 [4];
	logic [SW-1:0] rnd [4];

	always_ff @(posedge clk) begin
		if (en_w) begin
			w00_s4 <= WW'(ONE - fx) * WW'(ONE - fy);
			w10_s4 <= WW'(fx) * WW'(ONE - fy);
			w01_s4 <= WW'(ONE - fx) * WW'(fy);
			w11_s4 <= WW'(fx) * WW'(fy);
			q00_s4 <= p00;
			q10_s4 <= p10;
			q01_s4 <= p01;
			q11_s4 <= p11;
		end
	end

	always_ff @(posedge clk) begin
		if (en_m) begin
			for (int k = 0; k < 4; k++) begin
				sum_s5[k] <= SW'(q00_s4[8*k +: 8]) * SW'(w00_s4)
					+ SW'(q10_s4[8*k +: 8]) * SW'(w10_s4)
					+ SW'(q01_s4[8*k +: 8]) * SW'(w01_s4)
					+ SW'(q11_s4[8*k +: 8]) * SW'(w11_s4);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rnd[k] = (sum_s5[k] + (SW'(1) << (SUM_SHIFT - 1))) >> SUM_SHIFT;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			for (int k = 0; k < 4; k++) begin
				result[8*k +: 8] <= (rnd[k] > SW'(255)) ? 8'hff : rnd[k][7:0];
			end
		end
	end
endmodule

FILE: hw/rtl/bilinear_rgba_scaler_top.sv
// ----------------------------------------------------------------------------
// Bilinear RGBA scaler
// Loads a source image into a frame store and answers destination pixels.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one transaction per clock unless stalled.
// A load transaction (opcode 0) writes a source pixel and gives no result;
// a request transaction (opcode 1) gives one output transaction carrying
// the interpolated pixel. Requests pass six register stages: step
// multiply, clamp, frame store read, weights, channel multiply-add, round
// and output, at one item per cycle unless the pipeline stalls. A load is
// written two stages after it is taken, where requests read the frame
// store, so a request sees every load taken before it and none taken after
// it. Reset clears the valid bits and sets the configuration to width 1,
// height 1 and unit steps; the frame store holds no reset value. When the
// receiver stalls while the output stage is full, the whole pipeline holds
// and stall is passed back to the sender, so nothing is lost.
// Configuration is written through wr_en, wr_index and wr_data; the user
// must write it only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bilinear_rgba_scaler_top import brs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  column,
	input  logic [7:0]  row,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	input  logic [7:0]  in_alpha,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_column,
	output logic [7:0]  out_row,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [23:0] wr_data
);
	localparam int NS = 6;
	logic [8:0] width_q, height_q;
	logic [23:0] hstep_q, vstep_q;
	logic [XW:0] wid;
	logic [YW:0] hgt;
	logic [NS-1:0] vld_s;
	logic [15:0] pos_s [NS];
	logic adv;
	logic ld_ok;
	logic ld_vld_s1, ld_vld_s2;
	logic [XW+YW-1:0] ld_addr_s1, ld_addr_s2;
	pixel_t ld_data_s1, ld_data_s2;
	logic ld_wr;
	coord_t coord;
	pixel_t p00, p10, p01, p11, result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd1;
			height_q <= 9'd1;
			hstep_q <= 24'd65536;
			vstep_q <= 24'd65536;
		end else if (wr_en) begin
			case (wr_index)
				REG_WIDTH:  width_q <= wr_data[8:0];
				REG_HEIGHT: height_q <= wr_data[8:0];
				REG_HSTEP:  hstep_q <= wr_data;
				REG_VSTEP:  vstep_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		wid = (width_q == 9'd0) ? (XW+1)'(1) :
			(width_q > 9'(MAX_WIDTH)) ? (XW+1)'(MAX_WIDTH) : (XW+1)'(width_q);
		hgt = (height_q == 9'd0) ? (YW+1)'(1) :
			(height_q > 9'(MAX_HEIGHT)) ? (YW+1)'(MAX_HEIGHT) : (YW+1)'(height_q);
	end

	assign adv = !(vld_s[NS-1] && out_stall);
	assign in_stall = !adv;
	assign ld_ok = in_valid && adv && opcode == OP_LOAD
		&& (XW+1)'(column) < wid && (YW+1)'(row) < hgt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NS-2:0], in_valid && opcode == OP_REQUEST};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s[0] <= {row, column};
			for (int k = 1; k < NS; k++) begin
				pos_s[k] <= pos_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_vld_s1 <= 1'b0;
			ld_vld_s2 <= 1'b0;
		end else if (adv) begin
			ld_vld_s1 <= ld_ok;
			ld_vld_s2 <= ld_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ld_addr_s1 <= {row[YW-1:0], column[XW-1:0]};
			ld_data_s1 <= {in_alpha, in_blue, in_green, in_red};
			ld_addr_s2 <= ld_addr_s1;
			ld_data_s2 <= ld_data_s1;
		end
	end

	assign ld_wr = ld_vld_s2 && adv;

	brs_addr u_addr (
		.clk(clk), .en(adv), .column(column), .row(row), .hstep(hstep_q),
		.vstep(vstep_q), .wid(wid), .hgt(hgt), .coord(coord)
	);

	brs_store u_store (
		.clk(clk), .en(adv), .wr_en(ld_wr),
		.wr_addr(ld_addr_s2),
		.wr_data(ld_data_s2),
		.coord(coord), .p00(p00), .p10(p10), .p01(p01), .p11(p11)
	);

	coord_t coord_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			coord_s3 <= coord;
		end
	end

	brs_blend u_blend (
		.clk(clk), .en_w(adv), .en_m(adv), .en_o(adv),
		.fx(coord_s3.fx), .fy(coord_s3.fy),
		.p00(p00), .p10(p10), .p01(p01), .p11(p11), .result(result)
	);

	assign out_valid = vld_s[NS-1];
	assign out_column = pos_s[NS-1][7:0];
	assign out_row = pos_s[NS-1][15:8];
	assign out_red = result[7:0];
	assign out_green = result[15:8];
	assign out_blue = result[23:16];
	assign out_alpha = result[31:24];
endmodule

FILE: hw/rtl/brs_checker.sv
// ----------------------------------------------------------------------------
// Bilinear scaler port checker
// Watches the top-level ports for handshake and flow rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module brs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_column
);
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_column))
	`CHK_IMPLY(a_stall_only_full, clk, arst_n, in_stall, out_valid && out_stall)
	`CHK_IMPLY(a_free_when_empty, clk, arst_n, !out_valid, !in_stall)
endmodule

bind bilinear_rgba_scaler_top brs_checker u_brs_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_column(out_column)
);

FILE: tb/tb_bilinear_rgba_scaler_top.sv
// ----------------------------------------------------------------------------
// Bilinear RGBA scaler testbench
// Loads source pixels and requests destination pixels under several sizes and
// steps, predicts each interpolated pixel from a private copy of the frame
// store and the registers, and compares every output transaction in order.
// The input channel idles and the output channel stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bilinear_rgba_scaler_top;
	import brs_pkg::*;

	localparam int RUN_LIMIT = 1000000;

	typedef struct packed {
		logic [7:0] col;
		logic [7:0] row;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} scaled_pixel_t;

	class scaler_scoreboard;
		pixel_t frame [MAX_WIDTH*MAX_HEIGHT];
		bit loaded [MAX_WIDTH*MAX_HEIGHT];
		int unsigned src_w = 1;
		int unsigned src_h = 1;
		int unsigned h_step = 65536;
		int unsigned v_step = 65536;
		scaled_pixel_t awaited [$];
		int mismatches = 0;

		function int unsigned clamp_size(int unsigned v, int unsigned maxv);
			if (v == 0) return 1;
			if (v > maxv) return maxv;
			return v;
		endfunction

		function void set_register(logic [1:0] idx, logic [23:0] value);
			case (idx)
				REG_WIDTH: src_w = value[8:0];
				REG_HEIGHT: src_h = value[8:0];
				REG_HSTEP: h_step = value;
				REG_VSTEP: v_step = value;
				default: ;
			endcase
		endfunction

		// Frame store addresses of the four neighbours, plus the two fractions.
		function void locate(logic [7:0] c, logic [7:0] r, output int addr[4],
				output int unsigned fx, output int unsigned fy);
			longint unsigned xs, ys;
			int unsigned w, h, x0, x1, y0, y1;
			w = clamp_size(src_w, MAX_WIDTH);
			h = clamp_size(src_h, MAX_HEIGHT);
			xs = longint'(c) * h_step;
			ys = longint'(r) * v_step;
			fx = 32'((xs >> 8) & 255);
			fy = 32'((ys >> 8) & 255);
			x0 = ((xs >> 16) > w - 1) ? w - 1 : int'(xs >> 16);
			y0 = ((ys >> 16) > h - 1) ? h - 1 : int'(ys >> 16);
			x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
			y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
			addr[0] = y0 * MAX_WIDTH + x0;
			addr[1] = y0 * MAX_WIDTH + x1;
			addr[2] = y1 * MAX_WIDTH + x0;
			addr[3] = y1 * MAX_WIDTH + x1;
		endfunction

		function void note_input(logic op, logic [7:0] c, logic [7:0] r, pixel_t px);
			int addr[4];
			int unsigned fx, fy, sum;
			int unsigned wt[4];
			scaled_pixel_t e;
			logic [7:0] ch[4];
			if (op == OP_LOAD) begin
				if (c < clamp_size(src_w, MAX_WIDTH) && r < clamp_size(src_h, MAX_HEIGHT)) begin
					frame[r * MAX_WIDTH + c] = px;
					loaded[r * MAX_WIDTH + c] = 1;
				end
				return;
			end
			locate(c, r, addr, fx, fy);
			wt[0] = (256 - fx) * (256 - fy);
			wt[1] = fx * (256 - fy);
			wt[2] = (256 - fx) * fy;
			wt[3] = fx * fy;
			for (int k = 0; k < 4; k++) begin
				sum = 0;
				for (int n = 0; n < 4; n++)
					sum += frame[addr[n]][8*k +: 8] * wt[n];
				sum = (sum + 32768) >> 16;
				ch[k] = (sum > 255) ? 8'd255 : sum[7:0];
			end
			e.col = c;
			e.row = r;
			e.red = ch[0];
			e.green = ch[1];
			e.blue = ch[2];
			e.alpha = ch[3];
			awaited.push_back(e);
		endfunction

		function void check_result(scaled_pixel_t got);
			scaled_pixel_t e;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output: col %0d row %0d rgba %h", got.col, got.row,
						{got.red, got.green, got.blue, got.alpha});
				return;
			end
			e = awaited.pop_front();
			if (got.col != e.col || got.row != e.row || got.red != e.red ||
					got.green != e.green || got.blue != e.blue || got.alpha != e.alpha) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected col %0d row %0d rgba %h, got col %0d row %0d rgba %h",
						e.col, e.row, {e.red, e.green, e.blue, e.alpha},
						got.col, got.row, {got.red, got.green, got.blue, got.alpha});
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic opcode;
	logic [7:0] column;
	logic [7:0] row;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	logic [7:0] in_alpha;
	logic out_valid;
	logic out_stall;
	logic [7:0] out_column;
	logic [7:0] out_row;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic wr_en;
	logic [1:0] wr_index;
	logic [23:0] wr_data;

	scaler_scoreboard sb;
	bit calm;
	int unsigned cycles;

	bilinear_rgba_scaler_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.column(column), .row(row),
		.in_red(in_red), .in_green(in_green), .in_blue(in_blue), .in_alpha(in_alpha),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_column(out_column), .out_row(out_row),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int pause_length();
		int p;
		if (calm) return 0;
		p = $urandom_range(0, 99);
		if (p < 70) return 0;
		if (p < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		int hold;
		scaled_pixel_t got;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = {out_column, out_row, out_red, out_green, out_blue, out_alpha};
				sb.check_result(got);
			end
			if (hold == 0)
				hold = pause_length();
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > RUN_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic send_item(input logic op, input logic [7:0] c, input logic [7:0] r,
			input pixel_t px);
		int g;
		g = pause_length();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		column <= c;
		row <= r;
		{in_alpha, in_blue, in_green, in_red} <= px;
		do @(posedge clk); while (in_stall);
		sb.note_input(op, c, r, px);
	endtask

	// Loads any neighbour not yet written, so that no unwritten entry is read.
	task automatic request_pixel(input logic [7:0] c, input logic [7:0] r);
		int addr[4];
		int unsigned fx, fy;
		sb.locate(c, r, addr, fx, fy);
		for (int n = 0; n < 4; n++)
			if (!sb.loaded[addr[n]])
				send_item(OP_LOAD, 8'(addr[n] % MAX_WIDTH), 8'(addr[n] / MAX_WIDTH),
					$urandom);
		send_item(OP_REQUEST, c, r, $urandom);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [23:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		sb.set_register(idx, value);
	endtask

	task automatic set_geometry(input int unsigned w, input int unsigned h,
			input int unsigned hs, input int unsigned vs);
		wait_drained();
		write_register(REG_WIDTH, {15'($urandom_range(0, 32767)), 9'(w)});
		write_register(REG_HEIGHT, {15'($urandom_range(0, 32767)), 9'(h)});
		write_register(REG_HSTEP, 24'(hs));
		write_register(REG_VSTEP, 24'(vs));
		wr_en <= 1'b0;
	endtask

	function automatic int unsigned fit_step(int unsigned s, int unsigned d);
		if (d < 2) d = 2;
		return (((s - 1) * 131072) / (d - 1) + 1) / 2;
	endfunction

	task automatic random_traffic(input int n, input int unsigned dw, input int unsigned dh);
		int p;
		int unsigned w, h;
		w = sb.clamp_size(sb.src_w, MAX_WIDTH);
		h = sb.clamp_size(sb.src_h, MAX_HEIGHT);
		if (dw * dh <= 64)
			for (int j = 0; j < dh; j++)
				for (int i = 0; i < dw; i++)
					request_pixel(8'(i), 8'(j));
		for (int k = 0; k < n; k++) begin
			p = $urandom_range(0, 99);
			if (p < 55)
				request_pixel(8'($urandom_range(0, dw - 1)), 8'($urandom_range(0, dh - 1)));
			else if (p < 70)
				request_pixel(8'($urandom), 8'($urandom));
			else if (p < 88)
				send_item(OP_LOAD, 8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)),
					$urandom);
			else
				send_item(OP_LOAD, 8'($urandom), 8'($urandom), $urandom);
		end
	endtask

	initial begin
		int unsigned w, h, dw, dh;
		sb = new();
		calm = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		out_stall <= 1'b0;
		opcode <= OP_LOAD;
		column <= 8'd0;
		row <= 8'd0;
		{in_alpha, in_blue, in_green, in_red} <= 32'd0;
		wr_en <= 1'b0;
		wr_index <= REG_WIDTH;
		wr_data <= 24'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_LOAD, 8'd0, 8'd0, 32'hFFFF_FFFF);
		send_item(OP_LOAD, 8'd1, 8'd0, 32'h1234_5678);
		send_item(OP_LOAD, 8'd0, 8'd1, 32'h1234_5678);
		send_item(OP_REQUEST, 8'd0, 8'd0, 32'd0);
		send_item(OP_REQUEST, 8'd255, 8'd255, 32'hFFFF_FFFF);

		set_geometry(2, 2, 24'h008000, 24'hFF0000);
		send_item(OP_LOAD, 8'd0, 8'd0, 32'h0000_0000);
		send_item(OP_LOAD, 8'd1, 8'd0, 32'hFFFF_FFFF);
		send_item(OP_LOAD, 8'd0, 8'd1, 32'hFF00_FF00);
		send_item(OP_LOAD, 8'd1, 8'd1, 32'h00FF_00FF);
		send_item(OP_LOAD, 8'd2, 8'd1, 32'h5555_5555);
		send_item(OP_REQUEST, 8'd0, 8'd0, 32'd0);
		send_item(OP_REQUEST, 8'd1, 8'd0, 32'd0);
		send_item(OP_REQUEST, 8'd1, 8'd1, 32'd0);
		send_item(OP_REQUEST, 8'd255, 8'd1, 32'd0);
		send_item(OP_REQUEST, 8'd3, 8'd0, 32'd0);

		set_geometry(0, 0, 0, 0);
		random_traffic(40, 4, 4);
		set_geometry(511, 3, 24'hFF0000, $urandom_range(0, 24'hFFFFFF));
		random_traffic(80, 256, 3);
		set_geometry(256, 256, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
		random_traffic(100, 256, 256);
		for (int ph = 0; ph < 6; ph++) begin
			calm = (ph == 2);
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 12);
			dw = $urandom_range(1, 16);
			dh = $urandom_range(1, 16);
			set_geometry(w, h, fit_step(w, dw), fit_step(h, dh));
			random_traffic(60, dw, dh);
		end
		calm = 1'b0;

		wait_drained();
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
